[src/bdr_pkg.sv]
// shared types and constants for the block difficulty retarget design
// no dependencies; used by bdr_muldiv and block_difficulty_retarget
package bdr_pkg;

  localparam int unsigned MaxSamples = 1024;
  localparam int unsigned AddrW      = $clog2(MaxSamples);
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned DataW      = 64;
  localparam int unsigned StepW      = $clog2(DataW) + 1;

  typedef enum logic [2:0] {
    CFG_TARGET_SPACING = 3'd0,
    CFG_CLASSIC_WINDOW = 3'd1,
    CFG_TRIM_COUNT     = 3'd2,
    CFG_TAIL_WINDOW    = 3'd3,
    CFG_TAIL_START     = 3'd4,
    CFG_FORCE_TAIL     = 3'd5,
    CFG_BOOST_AFTER    = 3'd6,
    CFG_BLOCKS_PER_DAY = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FEW       = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_STORE_OVF = 2'd3
  } status_e;

  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_e;

  typedef struct packed {
    logic             start;
    md_op_e           op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] hi;
    logic [DataW-1:0] lo;
  } md_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SETUP,
    S_BOUNDS,
    S_CAND_RD,
    S_CAND_LAT,
    S_SCAN,
    S_SCAN_END,
    S_WORK_RD0,
    S_WORK_RD1,
    S_WORK_LAT,
    S_MUL_START,
    S_MUL_WAIT,
    S_CHECK,
    S_DIV_WAIT,
    S_BDIV_START,
    S_BDIV_WAIT,
    S_BMUL_START,
    S_BMUL_WAIT,
    S_FINISH
  } state_e;

endpackage

[src/block_difficulty_retarget.sv]
// top level of the block difficulty retarget engine: sample stores and sequencer
// depends on bdr_pkg, bdr_ram, bdr_muldiv
//
//  channel   direction  transaction
//  s_axis    in         one sample: tdata = time, work, height; tlast closes the window
//  m_axis    out        one result per window: tdata = difficulty, tuser = status
//  cfg       in         register write: index and 32-bit data, always ready
//
// a sample that does not close the window is stored and counted; unless the window
// overflowed or holds under two samples, the closing sample starts a rank scan and then
// multiplies or divides on the shared unit (up to two in tail mode, up to four in classic
// mode with boost); the rank scan over the single time read port dominates
// asynchronous active-low reset clears control and restores register defaults
// the result waits in the output register; input stalls while a window computes
module block_difficulty_retarget (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,  // block_time, cumulative_work, chain_height
  input  logic         s_axis_tlast,  // last_sample
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // next_difficulty
  output logic [1:0]   m_axis_tuser,  // status
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import bdr_pkg::*;

  // configuration registers
  logic [31:0] target_q, tail_start_q, boost_after_q;
  logic [10:0] classic_win_q, tail_win_q;
  logic [8:0]  trim_q;
  logic        force_tail_q;
  logic [19:0] bpd_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q      <= 32'd120;
      classic_win_q <= 11'd720;
      trim_q        <= 9'd60;
      tail_win_q    <= 11'd17;
      tail_start_q  <= 32'd0;
      force_tail_q  <= 1'b0;
      boost_after_q <= 32'hFFFF_FFFF;
      bpd_q         <= 20'd720;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET_SPACING: target_q      <= cfg_data_i;
        CFG_CLASSIC_WINDOW: classic_win_q <= cfg_data_i[10:0];
        CFG_TRIM_COUNT:     trim_q        <= cfg_data_i[8:0];
        CFG_TAIL_WINDOW:    tail_win_q    <= cfg_data_i[10:0];
        CFG_TAIL_START:     tail_start_q  <= cfg_data_i;
        CFG_FORCE_TAIL:     force_tail_q  <= cfg_data_i[0];
        CFG_BOOST_AFTER:    boost_after_q <= cfg_data_i;
        CFG_BLOCKS_PER_DAY: bpd_q         <= cfg_data_i[19:0];
        default:            ;
      endcase
    end
  end

  state_e state_q, state_d;

  // input field split
  logic [DataW-1:0] in_time, in_work;
  logic [31:0]      in_height;
  assign in_time   = s_axis_tdata[63:0];
  assign in_work   = s_axis_tdata[127:64];
  assign in_height = s_axis_tdata[159:128];

  logic in_fire;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // window bookkeeping
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             store_we;
  assign store_we = in_fire && (cnt_q < CntW'(MaxSamples));

  // sequencer datapath registers
  logic [31:0]      height_q, height_d;
  logic             tail_q, tail_d;
  logic [CntW-1:0]  win_q, win_d, len_q, len_d, first_q, first_d;
  logic [CntW-1:0]  beg_q, beg_d, end_q, end_d;
  logic [CntW-1:0]  c_q, c_d, j_q, j_d, rank_q, rank_d;
  logic [DataW-1:0] cand_q, cand_d, lo_t_q, lo_t_d, hi_t_q, hi_t_d;
  logic [DataW-1:0] wlo_q, wlo_d, work_q, work_d, span_q, span_d, diff_q, diff_d;
  logic [DataW-1:0] res_q, res_d;
  status_e          stat_q, stat_d;

  // memories
  logic [AddrW-1:0] rd_addr;
  logic [DataW-1:0] time_rd, work_rd;

  bdr_ram #(.Width(DataW), .Depth(MaxSamples)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (in_time),
    .raddr_i (rd_addr),
    .rdata_o (time_rd)
  );

  bdr_ram #(.Width(DataW), .Depth(MaxSamples)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (in_work),
    .raddr_i (rd_addr),
    .rdata_o (work_rd)
  );

  // shared multiply / divide unit
  md_req_t md_req;
  md_rsp_t md_rsp;

  bdr_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // helper terms
  logic [CntW-1:0] trim2, kept, len_pick;
  logic [DataW:0]  round_sum;
  logic            rank_hit, out_free, boost_on;
  logic [19:0]     bpd_eff;

  assign trim2     = CntW'({trim_q, 1'b0});
  assign kept      = ((trim2 + CntW'(2)) > win_q) ? CntW'(2) : (win_q - trim2);
  assign len_pick  = (cnt_q < win_q) ? cnt_q : win_q;
  assign round_sum = {1'b0, md_rsp.lo} + {1'b0, span_q} - 1'b1;
  assign rank_hit  = (time_rd < cand_q) || ((time_rd == cand_q) && (j_q < c_q));
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign boost_on  = {1'b0, height_q} > ({1'b0, boost_after_q} + 33'd1);
  assign bpd_eff   = (bpd_q == '0) ? 20'd1 : bpd_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:       if (in_fire && s_axis_tlast) state_d = S_SETUP;
      S_SETUP:      state_d = S_BOUNDS;
      S_BOUNDS: begin
        if (ovf_q || len_pick <= CntW'(1)) state_d = S_FINISH;
        else                               state_d = S_CAND_RD;
      end
      S_CAND_RD:    state_d = S_CAND_LAT;
      S_CAND_LAT:   state_d = S_SCAN;
      S_SCAN:       if (j_q == len_q - 1'b1) state_d = S_SCAN_END;
      S_SCAN_END:   state_d = (c_q == len_q - 1'b1) ? S_WORK_RD0 : S_CAND_RD;
      S_WORK_RD0:   state_d = S_WORK_RD1;
      S_WORK_RD1:   state_d = S_WORK_LAT;
      S_WORK_LAT:   state_d = S_MUL_START;
      S_MUL_START:  state_d = S_MUL_WAIT;
      S_MUL_WAIT:   if (md_rsp.done) state_d = S_CHECK;
      S_CHECK: begin
        if (md_rsp.hi != '0 || round_sum[DataW]) state_d = S_FINISH;
        else                                     state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (md_rsp.done) state_d = (!tail_q && boost_on) ? S_BDIV_START : S_FINISH;
      end
      S_BDIV_START: state_d = S_BDIV_WAIT;
      S_BDIV_WAIT:  if (md_rsp.done) state_d = S_BMUL_START;
      S_BMUL_START: state_d = S_BMUL_WAIT;
      S_BMUL_WAIT:  if (md_rsp.done) state_d = S_FINISH;
      S_FINISH:     if (out_free) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    height_d = height_q;
    tail_d   = tail_q;
    win_d    = win_q;
    len_d    = len_q;
    first_d  = first_q;
    beg_d    = beg_q;
    end_d    = end_q;
    c_d      = c_q;
    j_d      = j_q;
    rank_d   = rank_q;
    cand_d   = cand_q;
    lo_t_d   = lo_t_q;
    hi_t_d   = hi_t_q;
    wlo_d    = wlo_q;
    work_d   = work_q;
    span_d   = span_q;
    diff_d   = diff_q;
    res_d    = res_q;
    stat_d   = stat_q;
    rd_addr  = '0;
    md_req   = '{start: 1'b0, op: MD_MUL, a: '0, b: '0};

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (store_we) cnt_d = cnt_q + 1'b1;
          else          ovf_d = 1'b1;
          height_d = in_height;
        end
      end
      S_SETUP: begin
        // mode select and effective window
        tail_d = force_tail_q || (height_q >= tail_start_q);
        if (force_tail_q || (height_q >= tail_start_q)) begin
          win_d = (tail_win_q < 11'd2) ? CntW'(2) : tail_win_q;
        end else begin
          win_d = (classic_win_q < 11'd2) ? CntW'(2) : classic_win_q;
        end
      end
      S_BOUNDS: begin
        len_d   = len_pick;
        first_d = tail_q ? (cnt_q - len_pick) : '0;
        if (tail_q || len_pick <= kept) begin
          beg_d = '0;
          end_d = len_pick;
        end else begin
          beg_d = (len_pick - kept + 1'b1) >> 1;
          end_d = ((len_pick - kept + 1'b1) >> 1) + kept;
        end
        c_d = '0;
        if (ovf_q) begin
          res_d  = '0;
          stat_d = ST_STORE_OVF;
        end else if (len_pick <= CntW'(1)) begin
          res_d  = 64'd1;
          stat_d = ST_FEW;
        end
      end
      S_CAND_RD:  rd_addr = AddrW'(first_q + c_q);
      S_CAND_LAT: begin
        cand_d  = time_rd;
        rd_addr = AddrW'(first_q);
        j_d     = '0;
        rank_d  = '0;
      end
      S_SCAN: begin
        // compare sample j against the candidate; fetch j+1
        rd_addr = AddrW'(first_q + j_q + 1'b1);
        if (rank_hit) rank_d = rank_q + 1'b1;
        j_d = j_q + 1'b1;
      end
      S_SCAN_END: begin
        if (rank_q == beg_q)         lo_t_d = cand_q;
        if (rank_q == end_q - 1'b1)  hi_t_d = cand_q;
        c_d = c_q + 1'b1;
      end
      S_WORK_RD0: rd_addr = AddrW'(first_q + beg_q);
      S_WORK_RD1: begin
        // work at the lower bound arrives here
        rd_addr = AddrW'(first_q + end_q - 1'b1);
        wlo_d   = work_rd;
      end
      S_WORK_LAT: begin
        work_d = work_rd - wlo_q;
        span_d = (hi_t_q == lo_t_q) ? 64'd1 : (hi_t_q - lo_t_q);
      end
      S_MUL_START: begin
        md_req = '{start: 1'b1, op: MD_MUL, a: work_q, b: {32'd0, target_q}};
      end
      S_CHECK: begin
        if (md_rsp.hi != '0 || round_sum[DataW]) begin
          res_d  = '0;
          stat_d = ST_OVERFLOW;
        end else begin
          md_req = '{start: 1'b1, op: MD_DIV,
                     a: tail_q ? md_rsp.lo : round_sum[DataW-1:0], b: span_q};
        end
      end
      S_DIV_WAIT: begin
        if (md_rsp.done) begin
          diff_d = md_rsp.lo;
          res_d  = md_rsp.lo;
          stat_d = ST_OK;
        end
      end
      S_BDIV_START: begin
        md_req = '{start: 1'b1, op: MD_DIV,
                   a: {32'd0, height_q} + {44'd0, bpd_eff}, b: {44'd0, bpd_eff}};
      end
      S_BMUL_START: begin
        md_req = '{start: 1'b1, op: MD_MUL, a: diff_q, b: md_rsp.lo};
      end
      S_BMUL_WAIT: begin
        if (md_rsp.done) res_d = diff_q + md_rsp.lo;
      end
      S_FINISH: begin
        if (out_free) begin
          cnt_d = '0;
          ovf_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    height_q <= height_d;
    tail_q   <= tail_d;
    win_q    <= win_d;
    len_q    <= len_d;
    first_q  <= first_d;
    beg_q    <= beg_d;
    end_q    <= end_d;
    c_q      <= c_d;
    j_q      <= j_d;
    rank_q   <= rank_d;
    cand_q   <= cand_d;
    lo_t_q   <= lo_t_d;
    hi_t_q   <= hi_t_d;
    wlo_q    <= wlo_d;
    work_q   <= work_d;
    span_q   <= span_d;
    diff_q   <= diff_d;
    res_q    <= res_d;
    stat_q   <= stat_d;
  end

  // output register
  logic             out_valid_q;
  logic [DataW-1:0] out_data_q;
  status_e          out_stat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_FINISH && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FINISH && out_free) begin
      out_data_q <= res_q;
      out_stat_q <= stat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;

endmodule

[src/bdr_ram.sv]
// generic single-write, single-read memory with registered read data
// no dependencies
module bdr_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/bdr_muldiv.sv]
// shared iterative unit: shift-add multiply and restoring divide, one bit a cycle
// depends on bdr_pkg
module bdr_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bdr_pkg::md_req_t req_i,
  output bdr_pkg::md_rsp_t rsp_o
);
  import bdr_pkg::*;

  logic [DataW-1:0] hi_q, hi_d, lo_q, lo_d, op_a_q, op_a_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  md_op_e           op_q, op_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DataW:0]   add_sum, shifted, diff;

  always_comb begin
    hi_d    = hi_q;
    lo_d    = lo_q;
    op_a_d  = op_a_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    add_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, op_a_q} : '0);
    shifted = {hi_q, lo_q[DataW-1]};
    diff    = shifted - {1'b0, op_a_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = StepW'(DataW);
      hi_d   = '0;
      if (req_i.op == MD_MUL) begin
        op_a_d = req_i.a;
        lo_d   = req_i.b;
      end else begin
        op_a_d = req_i.b;
        lo_d   = req_i.a;
      end
    end else if (busy_q) begin
      if (op_q == MD_MUL) begin
        hi_d = add_sum[DataW:1];
        lo_d = {add_sum[0], lo_q[DataW-1:1]};
      end else if (!diff[DataW]) begin
        hi_d = diff[DataW-1:0];
        lo_d = {lo_q[DataW-2:0], 1'b1};
      end else begin
        hi_d = shifted[DataW-1:0];
        lo_d = {lo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= MD_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    op_a_q <= op_a_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.hi   = hi_q;
  assign rsp_o.lo   = lo_q;

endmodule
